@@ rtl/assert_macros.svh @@
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising clk edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every rising clk edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/cdt_pkg.sv @@
package cdt_pkg;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] CFG_SECOND_LENGTH = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SLOT          = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_ADD_HOLD      = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_BEEP_QUIET    = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_BEEP_SOUND    = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_BEEP_REPEATS  = 3'd5;

  localparam logic [7:0] SEG_DARK   = 8'hff;
  localparam logic [3:0] DIGIT_DARK = 4'hf;

  typedef struct packed {
    logic       beep_level;
    logic [3:0] digit_enable;
    logic [7:0] segments;
  } result_t;

  typedef struct packed {
    logic [3:0] tens;
    logic [3:0] units;
  } bcd_t;

  // Split 0..127 into decimal digits: multiply by 205/2048 for the tens.
  function automatic bcd_t split_dec(input logic [6:0] v);
    logic [14:0] prod;
    logic [3:0]  q;
    logic [6:0]  q10;
    bcd_t        r;
    prod   = v * 8'd205;
    q      = prod[14:11];
    q10    = {q, 3'b000} + {2'b00, q, 1'b0};
    r.tens  = q;
    r.units = 4'(v - q10);
    return r;
  endfunction

  function automatic logic [7:0] seg_pattern(input logic [3:0] d);
    logic [7:0] s;
    unique case (d)
      4'd0:    s = 8'hc0;
      4'd1:    s = 8'hf9;
      4'd2:    s = 8'ha4;
      4'd3:    s = 8'hb0;
      4'd4:    s = 8'h99;
      4'd5:    s = 8'h92;
      4'd6:    s = 8'h82;
      4'd7:    s = 8'hf8;
      4'd8:    s = 8'h80;
      4'd9:    s = 8'h90;
      default: s = SEG_DARK;
    endcase
    return s;
  endfunction

endpackage

@@ rtl/cdt_display.sv @@
module cdt_display (
  input  logic [6:0]       minutes,
  input  logic [5:0]       seconds,
  input  logic [1:0]       digit_index,
  input  logic             dark,
  input  logic             beep_sounding,
  output cdt_pkg::result_t result
);
  import cdt_pkg::*;

  bcd_t       min_dec;
  bcd_t       sec_dec;
  logic [3:0] digit_val;

  assign min_dec = split_dec(minutes);
  assign sec_dec = split_dec({1'b0, seconds});

  always_comb begin
    unique case (digit_index)
      2'd0: digit_val = min_dec.tens;
      2'd1: digit_val = min_dec.units;
      2'd2: digit_val = sec_dec.tens;
      2'd3: digit_val = sec_dec.units;
    endcase
    if (dark) begin
      result.segments     = SEG_DARK;
      result.digit_enable = DIGIT_DARK;
      result.beep_level   = beep_sounding;
    end else begin
      result.segments     = seg_pattern(digit_val);
      result.digit_enable = ~(4'b0001 << digit_index);
      result.beep_level   = 1'b0;
    end
  end

endmodule

@@ rtl/countdown_timer_seven_segment.sv @@
// Countdown timer with a four-digit multiplexed display. Each input transfer is one
// millisecond tick carrying the add and start button levels; each tick gives exactly
// one output transfer showing the display and beep state from before that tick's
// update. A tick is taken in every cycle that s_tready is high: the state update is one
// pass of counter logic, and the result is registered in the output register, or in the
// skid stage behind it while a result waits on m_tready, which lets one more tick in, so
// s_tready only drops after two results are held. Configuration writes are taken at any
// cycle and should be made while no tick is in flight.
module countdown_timer_seven_segment (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [7:0]                           s_tdata,   // [0] add_button, [1] start_button
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [15:0]                          m_tdata,   // [7:0] segments,
                                                          // [11:8] digit_enable,
                                                          // [12] beep_level
  input  logic                                 cfg_we,
  input  logic [cdt_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [cdt_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import cdt_pkg::*;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_HOLD  = 2'd1,
    PH_COUNT = 2'd2,
    PH_BEEP  = 2'd3
  } phase_t;

  logic [15:0] second_length_ms;
  logic [7:0]  slot_ms;
  logic [15:0] add_hold_ms;
  logic [15:0] beep_quiet_ms;
  logic [15:0] beep_sound_ms;
  logic [3:0]  beep_repeats;

  phase_t      phase, phase_next;
  logic [6:0]  minutes, minutes_next;
  logic [5:0]  seconds, seconds_next;
  logic [15:0] phase_ticks, phase_ticks_next;
  logic [7:0]  slot_ticks, slot_ticks_next;
  logic [1:0]  digit_index, digit_index_next;
  logic [3:0]  beep_count, beep_count_next;
  logic        beep_sounding, beep_sounding_next;

  logic        accept;
  logic        add_pressed;
  logic        start_pressed;
  logic [15:0] phase_len;
  logic        phase_hit;
  logic        slot_hit;
  logic        scan_end;
  logic        try_start;
  result_t     result;
  result_t     out_data;
  result_t     skid_data;
  logic        skid_valid;

  assign s_tready      = !skid_valid;
  assign accept        = s_tvalid && s_tready;
  assign add_pressed   = !s_tdata[0];
  assign start_pressed = !s_tdata[1];
  assign m_tdata       = {3'b000, out_data};

  cdt_display u_display (
    .minutes       (minutes),
    .seconds       (seconds),
    .digit_index   (digit_index),
    .dark          (phase == PH_BEEP),
    .beep_sounding (beep_sounding),
    .result        (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      second_length_ms <= 16'd1000;
      slot_ms          <= 8'd10;
      add_hold_ms      <= 16'd280;
      beep_quiet_ms    <= 16'd1000;
      beep_sound_ms    <= 16'd1000;
      beep_repeats     <= 4'd3;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SECOND_LENGTH: second_length_ms <= cfg_data;
        CFG_SLOT:          slot_ms          <= cfg_data[7:0];
        CFG_ADD_HOLD:      add_hold_ms      <= cfg_data;
        CFG_BEEP_QUIET:    beep_quiet_ms    <= cfg_data;
        CFG_BEEP_SOUND:    beep_sound_ms    <= cfg_data;
        CFG_BEEP_REPEATS:  beep_repeats     <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (phase)
      PH_HOLD:  phase_len = add_hold_ms;
      PH_BEEP:  phase_len = beep_sounding ? beep_sound_ms : beep_quiet_ms;
      default:  phase_len = second_length_ms;
    endcase
  end

  assign phase_hit = ({1'b0, phase_ticks} + 17'd1) >= {1'b0, phase_len};
  assign slot_hit  = ({1'b0, slot_ticks} + 9'd1) >= {1'b0, slot_ms};

  always_comb begin
    phase_next         = phase;
    minutes_next       = minutes;
    seconds_next       = seconds;
    phase_ticks_next   = phase_ticks;
    slot_ticks_next    = slot_ticks;
    digit_index_next   = digit_index;
    beep_count_next    = beep_count;
    beep_sounding_next = beep_sounding;
    scan_end           = 1'b0;
    try_start          = 1'b0;

    if (accept) begin
      if (phase == PH_BEEP) begin
        if (phase_hit) begin
          phase_ticks_next = '0;
          if (!beep_sounding) begin
            beep_sounding_next = 1'b1;
          end else begin
            beep_sounding_next = 1'b0;
            if (({1'b0, beep_count} + 5'd1) >= {1'b0, beep_repeats}) begin
              beep_count_next  = '0;
              phase_next       = PH_IDLE;
              slot_ticks_next  = '0;
              digit_index_next = '0;
            end else begin
              beep_count_next = beep_count + 4'd1;
            end
          end
        end else begin
          phase_ticks_next = phase_ticks + 16'd1;
        end
      end else begin
        if (slot_hit) begin
          slot_ticks_next  = '0;
          scan_end         = (digit_index == 2'd3);
          digit_index_next = digit_index + 2'd1;
        end else begin
          slot_ticks_next = slot_ticks + 8'd1;
        end

        unique case (phase)
          PH_IDLE: begin
            if (scan_end) begin
              if (add_pressed) begin
                minutes_next     = (minutes >= 7'd99) ? 7'd0 : minutes + 7'd1;
                phase_ticks_next = '0;
                if (add_hold_ms == 16'd0) begin
                  try_start = 1'b1;
                end else begin
                  phase_next = PH_HOLD;
                end
              end else begin
                try_start = 1'b1;
              end
            end
          end
          PH_HOLD: begin
            if (phase_hit) begin
              try_start = 1'b1;
            end else begin
              phase_ticks_next = phase_ticks + 16'd1;
            end
          end
          default: begin
            if (phase_hit) begin
              phase_ticks_next = '0;
              if (seconds == 6'd0) begin
                seconds_next = 6'd59;
                minutes_next = (minutes == 7'd0) ? 7'd0 : minutes - 7'd1;
              end else begin
                seconds_next = seconds - 6'd1;
              end
              if (minutes_next == 7'd0 && seconds_next == 6'd0) begin
                phase_next         = PH_BEEP;
                beep_count_next    = '0;
                beep_sounding_next = 1'b0;
              end
            end else begin
              phase_ticks_next = phase_ticks + 16'd1;
            end
          end
        endcase

        if (try_start) begin
          if (start_pressed) begin
            phase_ticks_next = '0;
            if (minutes_next == 7'd0 && seconds_next == 6'd0) begin
              phase_next         = PH_BEEP;
              beep_count_next    = '0;
              beep_sounding_next = 1'b0;
            end else begin
              phase_next = PH_COUNT;
            end
          end else begin
            phase_next = PH_IDLE;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      minutes       <= '0;
      seconds       <= '0;
      phase_ticks   <= '0;
      slot_ticks    <= '0;
      digit_index   <= '0;
      beep_count    <= '0;
      beep_sounding <= 1'b0;
    end else begin
      phase         <= phase_next;
      minutes       <= minutes_next;
      seconds       <= seconds_next;
      phase_ticks   <= phase_ticks_next;
      slot_ticks    <= slot_ticks_next;
      digit_index   <= digit_index_next;
      beep_count    <= beep_count_next;
      beep_sounding <= beep_sounding_next;
    end
  end

  // output register plus skid stage
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!m_tvalid || m_tready) begin
      if (skid_valid) begin
        out_data   <= skid_data;
        skid_valid <= 1'b0;
      end else begin
        m_tvalid <= accept;
        if (accept) begin
          out_data <= result;
        end
      end
    end else if (accept) begin
      skid_data  <= result;
      skid_valid <= 1'b1;
    end
  end

endmodule

@@ rtl/cdt_checker.sv @@
module cdt_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [7:0]  s_tdata,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata
);
`include "assert_macros.svh"

  `ASSERT_CLK(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "output transfer changed while stalled")
  `ASSERT_ALWAYS(a_reset_empty, $past(rst) |-> !m_tvalid, "output valid right after reset")
  `ASSERT_CLK(a_ready_backpressure, !s_tready |-> m_tvalid, "input stalled with no result waiting")
  `ASSERT_CLK(a_display_form, m_tvalid |-> m_tdata[15:13] == 3'b000 && ((m_tdata[11:8] == 4'hf && m_tdata[7:0] == 8'hff) || ($onehot(~m_tdata[11:8]) && !m_tdata[12])), "bad display or beep pattern")
  `ASSERT_CLK(a_one_in_one_out, m_tvalid && m_tready && !(s_tvalid && s_tready) |=> s_tready, "input held stalled after output drained")

endmodule

bind countdown_timer_seven_segment cdt_checker u_cdt_checker (.*);
